/* hdl/trivariate_polynomial_evaluator_unit_macros.svh */
// Assertion macros shared by the evaluator RTL.
`ifndef TRIVARIATE_POLYNOMIAL_EVALUATOR_UNIT_MACROS_SVH
`define TRIVARIATE_POLYNOMIAL_EVALUATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, quiet while arst_n is low
`define TPE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpe assertion failed");
// next-cycle implication
`define TPE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpe assertion failed");
`else
`define TPE_ASSERT_IMP(label, ante, cons)
`define TPE_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* hdl/tpe_pkg.sv */
// Package: constants, payload types and sequencer states of the polynomial evaluator.
`default_nettype none

package tpe_pkg;

	localparam int MAX_ORDER   = 4;
	localparam int TABLE_DEPTH = 64;

	localparam int ADDR_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ORD_W     = $clog2(MAX_ORDER + 1);
	localparam int DIG_W     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
	localparam int REM_W     = DIG_W + 2;
	localparam int MAX_TERMS = MAX_ORDER * MAX_ORDER * MAX_ORDER;
	localparam int TERM_W    = ($clog2(MAX_TERMS + 1) > ADDR_W + 1) ?
		$clog2(MAX_TERMS + 1) : ADDR_W + 1;

	localparam int ACC_W  = 48;
	localparam int COEF_W = 32;
	localparam int X_W    = 16;
	localparam int FRAC_X = 12;
	localparam int PROD_W = ACC_W + X_W;
	localparam int IDX_W  = 6;

	localparam int ORDER_W   = 3;
	localparam int STEP_W    = 2;
	localparam int CFG_W     = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd1;
	localparam logic [STEP_W-1:0]  STEP_RESET  = 2'd1;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORDER = 1'b0,
		REG_STEP  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		op_t                      operation;
		logic [IDX_W-1:0]         coef_index;
		logic signed [COEF_W-1:0] coef_value;
		logic signed [X_W-1:0]    x0;
		logic signed [X_W-1:0]    x1;
		logic signed [X_W-1:0]    x2;
	} cmd_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] poly_value;
		logic                    inside_res;
		logic                    saturated;
	} res_t;

	// scaled, saturated term out of the shared multiplier
	typedef struct packed {
		logic signed [ACC_W-1:0] value;
		logic                    clip;
	} mul_res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_LD,
		S_DIM,
		S_MUL,
		S_SAT,
		S_ACC,
		S_NEXT,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

/* hdl/tpe_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none

module tpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hdl/tpe_mul_unit.sv */
// Shared multiplier: term times coordinate, floor shift by the point's fraction, 48-bit clip.
`default_nettype none

module tpe_mul_unit import tpe_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [ACC_W-1:0] t,
	input  wire logic signed [X_W-1:0]   x,
	output mul_res_t                     res
);

	logic signed [PROD_W-1:0] prod_c;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] shifted;
	logic [PROD_W-ACC_W-FRAC_X:0] hi;
	logic fits;

	assign prod_c = t * x;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= prod_c;
		end
	end

	// arithmetic shift gives floor division
	assign shifted = prod_q >>> FRAC_X;
	assign hi      = prod_q[PROD_W-1:ACC_W+FRAC_X-1];
	assign fits    = (&hi) | ~(|hi);

	always_comb begin
		res.clip  = ~fits;
		if (fits) begin
			res.value = shifted[ACC_W-1:0];
		end else if (prod_q[PROD_W-1]) begin
			res.value = ACC_MIN;
		end else begin
			res.value = ACC_MAX;
		end
	end

endmodule

`default_nettype wire

/* hdl/trivariate_polynomial_evaluator_unit.sv */
// Top level: trivariate polynomial evaluator with coefficient table and term sequencer.
// Load item: written in the accept cycle, busy never rises; next item may follow at once.
// Evaluate item: per term, S_RD and S_LD read its coefficient; a zero one goes straight to
//   S_NEXT, else S_DIM runs per coordinate with one S_MUL, S_SAT pass of the shared multiplier
//   per power (k0, k1, k2 times step powers), then S_ACC and S_NEXT. S_DONE follows the last
//   term's S_NEXT, or the accept at order zero; next item taken after done.
// Reset (arst_n low, asynchronous): table reads as zero, order 1, step 1, idle.
`default_nettype none
`include "trivariate_polynomial_evaluator_unit_macros.svh"

module trivariate_polynomial_evaluator_unit import tpe_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire cmd_t                 cmd,
	output logic                      done,
	output res_t                      result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	state_t state_q, state_d;

	logic [ORDER_W-1:0] order_q;
	logic [STEP_W-1:0]  step_q;

	// one valid bit per table entry: an unwritten entry reads as zero
	logic [TABLE_DEPTH-1:0] valid_q;
	logic                   rd_valid_q;

	logic signed [X_W-1:0] x0_q, x1_q, x2_q;
	logic [TERM_W-1:0]     term_q;
	logic [DIG_W-1:0]      k0_q, k1_q, k2_q;
	logic [1:0]            dim_q;     // 0, 1, 2: which coordinate is being applied
	logic [REM_W-1:0]      rem_q;     // multiplications left after the current one
	logic signed [ACC_W-1:0] t_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                  clip_q;

	// ------------------------------------------------------------------
	// Combinational helpers
	// ------------------------------------------------------------------
	logic                    accept, eval_acc, load_acc;
	logic [ORD_W-1:0]        ord_eff, ord_m1;
	logic [COEF_W-1:0]       rdata;
	logic signed [COEF_W-1:0] coef;
	logic [DIG_W-1:0]        k_cur;
	logic signed [X_W-1:0]   x_cur;
	logic [REM_W-1:0]        rem_calc;
	logic                    last_dim, last_term;
	logic signed [ACC_W:0]   sum;
	logic                    sum_ovf;
	logic                    mul_en;
	mul_res_t                mul_res;

	assign accept   = start & ~busy;
	assign eval_acc = accept & (cmd.operation == OP_EVAL);
	assign load_acc = accept & (cmd.operation == OP_LOAD) &
		(int'(cmd.coef_index) < TABLE_DEPTH);

	// orders above the maximum clamp to it
	assign ord_eff = (int'(order_q) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : ORD_W'(order_q);
	assign ord_m1  = ord_eff - ORD_W'(1);

	assign coef = rd_valid_q ? $signed(rdata) : '0;

	always_comb begin
		case (dim_q)
			2'd0:    begin k_cur = k0_q; x_cur = x0_q; end
			2'd1:    begin k_cur = k1_q; x_cur = x1_q; end
			default: begin k_cur = k2_q; x_cur = x2_q; end
		endcase
	end

	assign rem_calc = REM_W'(k_cur) * REM_W'(step_q);
	assign last_dim = (dim_q == 2'd2);

	// last term: all digits at order-1, or the table runs out
	assign last_term = ((ORD_W'(k0_q) == ord_m1) && (ORD_W'(k1_q) == ord_m1) &&
		(ORD_W'(k2_q) == ord_m1)) || (int'(term_q) + 1 >= TABLE_DEPTH);

	assign sum     = {acc_q[ACC_W-1], acc_q} + {t_q[ACC_W-1], t_q};
	assign sum_ovf = sum[ACC_W] ^ sum[ACC_W-1];

	// ------------------------------------------------------------------
	// Coefficient table and shared multiplier
	// ------------------------------------------------------------------
	tpe_ram #(
		.WIDTH(COEF_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (load_acc),
		.waddr(ADDR_W'(cmd.coef_index)),
		.wdata(cmd.coef_value),
		.raddr(term_q[ADDR_W-1:0]),
		.rdata(rdata)
	);

	tpe_mul_unit u_mul (
		.clk(clk),
		.en (mul_en),
		.t  (t_q),
		.x  (x_cur),
		.res(mul_res)
	);

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (eval_acc) begin
					state_d = (ord_eff == '0) ? S_DONE : S_RD;
				end
			end
			S_RD: state_d = S_LD;
			S_LD: state_d = (coef == '0) ? S_NEXT : S_DIM;
			S_DIM: begin
				if (rem_calc != '0) begin
					state_d = S_MUL;
				end else if (last_dim) begin
					state_d = S_ACC;
				end
			end
			S_MUL: state_d = S_SAT;
			S_SAT: begin
				if (rem_q != '0) begin
					state_d = S_MUL;
				end else if (last_dim) begin
					state_d = S_ACC;
				end else begin
					state_d = S_DIM;
				end
			end
			S_ACC:  state_d = S_NEXT;
			S_NEXT: state_d = last_term ? S_DONE : S_RD;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs
	// ------------------------------------------------------------------
	always_comb begin
		busy   = (state_q != S_IDLE);
		done   = (state_q == S_DONE);
		mul_en = (state_q == S_MUL);
		result.poly_value = acc_q;
		result.inside_res = (acc_q <= 0);
		result.saturated  = clip_q;
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			order_q    <= ORDER_RESET;
			step_q     <= STEP_RESET;
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			term_q     <= '0;
			k0_q       <= '0;
			k1_q       <= '0;
			k2_q       <= '0;
			dim_q      <= '0;
			rem_q      <= '0;
		end else begin
			state_q    <= state_d;
			rd_valid_q <= valid_q[term_q[ADDR_W-1:0]];

			if (cfg_we) begin
				unique case (cfg_index)
					REG_ORDER: order_q <= cfg_data[ORDER_W-1:0];
					REG_STEP:  step_q  <= cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end

			if (load_acc) begin
				valid_q[ADDR_W'(cmd.coef_index)] <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					term_q <= '0;
					k0_q   <= '0;
					k1_q   <= '0;
					k2_q   <= '0;
				end
				S_LD: dim_q <= '0;
				S_DIM: begin
					if (rem_calc != '0) begin
						rem_q <= rem_calc - REM_W'(1);
					end else if (!last_dim) begin
						dim_q <= dim_q + 2'd1;
					end
				end
				S_SAT: begin
					if (rem_q != '0) begin
						rem_q <= rem_q - REM_W'(1);
					end else if (!last_dim) begin
						dim_q <= dim_q + 2'd1;
					end
				end
				S_NEXT: begin
					// base-order digit counter alongside the linear index
					term_q <= term_q + TERM_W'(1);
					if (ORD_W'(k0_q) == ord_m1) begin
						k0_q <= '0;
						if (ORD_W'(k1_q) == ord_m1) begin
							k1_q <= '0;
							k2_q <= k2_q + DIG_W'(1);
						end else begin
							k1_q <= k1_q + DIG_W'(1);
						end
					end else begin
						k0_q <= k0_q + DIG_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (eval_acc) begin
					x0_q   <= cmd.x0;
					x1_q   <= cmd.x1;
					x2_q   <= cmd.x2;
					acc_q  <= '0;
					clip_q <= 1'b0;
				end
			end
			S_LD: t_q <= ACC_W'(coef);
			S_SAT: begin
				t_q    <= mul_res.value;
				clip_q <= clip_q | mul_res.clip;
			end
			S_ACC: begin
				if (sum_ovf) begin
					acc_q  <= sum[ACC_W] ? ACC_MIN : ACC_MAX;
					clip_q <= 1'b1;
				end else begin
					acc_q  <= sum[ACC_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`TPE_ASSERT_NXT(a_load_stays_idle, start && !busy && cmd.operation == OP_LOAD, !busy)
	`TPE_ASSERT_NXT(a_eval_goes_busy, start && !busy && cmd.operation == OP_EVAL, busy)
	`TPE_ASSERT_NXT(a_done_one_cycle, done, !done && !busy)
	`TPE_ASSERT_IMP(a_sat_after_mul, state_q == S_SAT, $past(state_q) == S_MUL)

endmodule

`default_nettype wire

/* bench/trivariate_polynomial_evaluator_unit_test.sv */
// Self-checking bench for the trivariate polynomial evaluator: queued stimulus, clocked driver and monitor.
`default_nettype none

module trivariate_polynomial_evaluator_unit_test;
	import tpe_pkg::*;

	// Timeout guard. Even if every item were a full order-4, step-3 evaluation, the run
	// would stay well below this.
	localparam longint CYCLE_LIMIT = 64'd20_000_000;
	// Do not print more mismatch lines than this; the rest are only counted.
	localparam int SHOWN_MISMATCHES = 20;
	localparam int PHASES = 12;

	// An item waiting for the driver. If hold_for_drain is set, the sender waits until
	// every awaited result has come back before it offers this item.
	typedef struct {
		cmd_t c;
		bit   hold_for_drain;
	} pending_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	cmd_t                 cmd = '0;
	logic                 done;
	res_t                 result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ORDER;
	logic [CFG_W-1:0]     cfg_data = '0;

	trivariate_polynomial_evaluator_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Period 20: high for 10, then low for 10.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the block state. It is updated at the same edges at which the block
	// takes a write or an item.
	logic signed [COEF_W-1:0] coef_table [TABLE_DEPTH];
	logic [ORDER_W-1:0]       order_reg = ORDER_RESET;
	logic [STEP_W-1:0]        step_reg  = STEP_RESET;

	pending_item_t cmd_backlog[$];      // items not yet offered to the block
	res_t          awaited_values[$];   // predicted results, oldest first

	bit     cmd_taken = 1'b0;   // the item now on cmd went in at the last rising edge
	bit     steady_run = 1'b0;  // turns off sender idling for one whole phase
	int     mismatch_count = 0;
	int     evals_checked = 0;
	int     loads_taken = 0;
	int     clipped_seen = 0;
	int     inside_seen = 0;
	longint cycle_count = 0;

	initial begin
		foreach (coef_table[j])
			coef_table[j] = '0;
	end

	// ---------------------------------------------------------------- prediction

	// Clip to 48 signed bits. The flag stays set once any clip has happened.
	function automatic longint clip48(input longint v, inout bit clipped);
		if (v > longint'(ACC_MAX)) begin
			clipped = 1'b1;
			return longint'(ACC_MAX);
		end
		if (v < longint'(ACC_MIN)) begin
			clipped = 1'b1;
			return longint'(ACC_MIN);
		end
		return v;
	endfunction

	// Work out the value of the polynomial at one point from the shadow table and registers.
	// A term starts as its coefficient in Q31.16. It is then multiplied by x0 k0*step times,
	// by x1 k1*step times and by x2 k2*step times. After each multiply the product is floored
	// by 2^12 and clipped. The terms are summed in index order into a clipping accumulator.
	function automatic res_t eval_polynomial(input logic signed [X_W-1:0] p0, p1, p2);
		res_t        r;
		int unsigned ord, terms, i, d;
		int unsigned k [3];
		longint      acc, term;
		longint      pt [3];
		bit          clipped;
		ord = (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
		terms = ord * ord * ord;
		pt[0] = longint'(p0);
		pt[1] = longint'(p1);
		pt[2] = longint'(p2);
		acc = 0;
		clipped = 1'b0;
		for (i = 0; i < terms && i < TABLE_DEPTH; i++) begin
			if (coef_table[i] == 0)
				continue;
			term = longint'(coef_table[i]);
			k[0] = i % ord;
			k[1] = (i / ord) % ord;
			k[2] = i / (ord * ord);
			for (d = 0; d < 3; d++)
				repeat (k[d] * step_reg)
					term = clip48((term * pt[d]) >>> FRAC_X, clipped);
			acc = clip48(acc + term, clipped);
		end
		r.poly_value = acc[ACC_W-1:0];
		r.inside_res = (acc <= 0);
		r.saturated  = clipped;
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	// Random coefficient. It is often full width, often near +-1.0, and sometimes zero or
	// an extreme value.
	function automatic logic signed [COEF_W-1:0] rand_coef();
		logic signed [COEF_W-1:0] v;
		case ($urandom_range(0, 7))
			0, 1: v = $urandom;
			2, 3: v = $signed($urandom_range(0, 131072)) - 65536;
			4: v = '0;
			5: begin
				case ($urandom_range(0, 3))
					0: v = 32'sh7FFF_FFFF;
					1: v = 32'sh8000_0000;
					2: v = 32'sd1;
					default: v = -32'sd1;
				endcase
			end
			default: v = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
		endcase
		return v;
	endfunction

	// Random coordinate. Values inside +-1.0 keep high powers finite. Full-range values and
	// extremes drive the products into clipping.
	function automatic logic signed [X_W-1:0] rand_coord();
		logic signed [X_W-1:0] v;
		case ($urandom_range(0, 7))
			0, 1: v = X_W'($urandom);
			2, 3: v = X_W'($signed($urandom_range(0, 8192)) - 4096);
			4: begin
				v = X_W'($urandom_range(4096, 8191));
				if ($urandom_range(0, 1))
					v = -v;
			end
			5: begin
				case ($urandom_range(0, 4))
					0: v = 16'sh7FFF;
					1: v = 16'sh8000;
					2: v = 16'sd4096;
					3: v = -16'sd4096;
					default: v = '0;
				endcase
			end
			default: v = X_W'($signed($urandom_range(0, 2048)) - 1024);
		endcase
		return v;
	endfunction

	// A load. The coordinate fields carry noise, which the block must ignore.
	function automatic void add_load(input logic [IDX_W-1:0] idx,
	                                 input logic signed [COEF_W-1:0] val);
		pending_item_t p;
		p.c.operation  = OP_LOAD;
		p.c.coef_index = idx;
		p.c.coef_value = val;
		p.c.x0 = X_W'($urandom);
		p.c.x1 = X_W'($urandom);
		p.c.x2 = X_W'($urandom);
		p.hold_for_drain = 1'b0;
		cmd_backlog.push_back(p);
	endfunction

	// An evaluate. The index and value fields carry noise.
	function automatic void add_eval(input logic signed [X_W-1:0] a, b, c, input bit hold);
		pending_item_t p;
		p.c.operation  = OP_EVAL;
		p.c.coef_index = IDX_W'($urandom);
		p.c.coef_value = $urandom;
		p.c.x0 = a;
		p.c.x1 = b;
		p.c.x2 = c;
		p.hold_for_drain = hold;
		cmd_backlog.push_back(p);
	endfunction

	// Wait until the block has nothing in hand, then a few cycles more. Loads finish in the
	// cycle in which they are taken, so a short margin is enough.
	task automatic settle();
		while (cmd_backlog.size() != 0 || awaited_values.size() != 0 || start)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatch_count < SHOWN_MISMATCHES)
			$display("[%0t] mismatch, %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// ---------------------------------------------------------------- driver

	// Drives at the falling edge. An item that is offered stays on cmd until the block takes
	// it. After that, the driver either idles at random or offers the next item.
	// An item marked hold_for_drain is held back while any result is still awaited.
	always @(negedge clk) begin
		pending_item_t nx;
		if (arst_n && !(start && !cmd_taken)) begin
			cmd_taken = 1'b0;
			if (cmd_backlog.size() != 0 &&
			    !(!steady_run && $urandom_range(0, 99) < 6) &&
			    !(cmd_backlog[0].hold_for_drain && awaited_values.size() != 0)) begin
				nx = cmd_backlog.pop_front();
				cmd   <= nx.c;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	// Samples at the rising edge. A result is checked against the oldest awaited one before
	// an item taken at the same edge is predicted. The register writes are mirrored here too.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (done) begin
				if (awaited_values.size() == 0) begin
					report_mismatch("result with none awaited",
						longint'($signed(result.poly_value)), 0);
				end else begin
					want = awaited_values.pop_front();
					if (result.poly_value !== want.poly_value)
						report_mismatch("poly_value", longint'($signed(result.poly_value)),
							longint'($signed(want.poly_value)));
					if (result.inside_res !== want.inside_res)
						report_mismatch("inside_res", longint'(result.inside_res),
							longint'(want.inside_res));
					if (result.saturated !== want.saturated)
						report_mismatch("saturated", longint'(result.saturated),
							longint'(want.saturated));
					evals_checked++;
					if (want.saturated)
						clipped_seen++;
					if (want.inside_res)
						inside_seen++;
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_ORDER: order_reg = cfg_data[ORDER_W-1:0];
					REG_STEP:  step_reg  = cfg_data[STEP_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				cmd_taken = 1'b1;
				if (cmd.operation == OP_EVAL) begin
					awaited_values.push_back(eval_polynomial(cmd.x0, cmd.x1, cmd.x2));
				end else begin
					coef_table[cmd.coef_index] = cmd.coef_value;
					loads_taken++;
				end
			end
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results still awaited",
					cycle_count, awaited_values.size());
				$display("** trivariate_polynomial_evaluator_unit: FAILED **");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		// Register settings for the random phases. Orders above MAX_ORDER must behave as
		// MAX_ORDER. Order zero gives an empty sum.
		int unsigned ord_plan  [PHASES] = '{2, 1, 3, 4, 5, 0, 7, 2, 3, 4, 6, 3};
		int unsigned step_plan [PHASES] = '{1, 3, 2, 3, 0, 2, 2, 3, 1, 1, 3, 0};
		int unsigned ph, eff, terms, added, n, m;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, at the reset setting (order 1, step 1). Only term 0 is used.
		add_eval(16'sh7FFF, 16'sh8000, 16'sh0000, 1'b0);    // table still empty after reset
		add_load(6'd0, 32'sh7FFF_FFFF);
		add_eval(16'sh7FFF, 16'sh8000, 16'sh0000, 1'b1);    // held until the one above is back
		add_load(6'd0, 32'sh8000_0000);
		add_eval(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
		add_load(6'd63, 32'sh7FFF_FFFF);                    // top table entry
		settle();

		// Order 4, step 3: nine powers per axis on the top term, so products clip.
		// Bit 2 of the data is set, and the step register must ignore it.
		write_reg(REG_ORDER, 3'd4);
		write_reg(REG_STEP, 3'b111);
		add_load(6'd1, 32'sh7FFF_FFFF);
		add_load(6'd21, 32'sh0001_0000);                    // x0*x1*x2 cubed, coefficient 1.0
		add_eval(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);    // positive clip then sum clip
		add_eval(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
		add_eval(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);    // all powers vanish, term 0 remains
		add_eval(16'sd4096, -16'sd4096, 16'sd4096, 1'b0);   // unit magnitudes
		settle();

		// Order zero: no terms are used.
		write_reg(REG_ORDER, 3'd0);
		write_reg(REG_STEP, 3'd0);
		add_eval(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
		settle();

		// Order 7 is clipped to 4. Step 0 turns every term into its plain coefficient.
		write_reg(REG_ORDER, 3'd7);
		add_eval(16'sh8000, 16'sh7FFF, 16'sh0000, 1'b0);
		settle();

		// Random part. Each phase is mostly short runs: a few loads into terms that are in use,
		// then evaluations at random points. Stray loads and lone evaluations are mixed in.
		for (ph = 0; ph < PHASES; ph++) begin
			write_reg(REG_ORDER, CFG_W'(ord_plan[ph]));
			write_reg(REG_STEP, {1'($urandom_range(0, 1)), 2'(step_plan[ph])});
			steady_run = (ph == 4);
			eff = (ord_plan[ph] > MAX_ORDER) ? MAX_ORDER : ord_plan[ph];
			terms = eff * eff * eff;
			if (terms == 0 || terms > TABLE_DEPTH)
				terms = TABLE_DEPTH;
			added = 0;
			while (added < 90) begin
				if ($urandom_range(0, 9) == 0) begin
					if ($urandom_range(0, 1))
						add_load(IDX_W'($urandom_range(0, TABLE_DEPTH - 1)), rand_coef());
					else
						add_eval(rand_coord(), rand_coord(), rand_coord(), 1'b0);
					added++;
				end else begin
					n = $urandom_range(1, 6);
					m = $urandom_range(1, 3);
					repeat (n)
						add_load(IDX_W'($urandom_range(0, terms - 1)), rand_coef());
					repeat (m)
						add_eval(rand_coord(), rand_coord(), rand_coord(),
							$urandom_range(0, 49) == 0);
					added += n + m;
				end
			end
			settle();
		end
		steady_run = 1'b0;

		// Every result is back. Give the block a little longer so that any extra strobe
		// would still be seen.
		repeat (64) @(posedge clk);

		$display("covered %0d loads and %0d evaluations over %0d register settings",
			loads_taken, evals_checked, PHASES + 4);
		$display("%0d results clipped, %0d at or below zero, %0d cycles, %0d mismatches",
			clipped_seen, inside_seen, cycle_count, mismatch_count);
		if (mismatch_count == 0 && awaited_values.size() == 0)
			$display("** trivariate_polynomial_evaluator_unit: PASSED **");
		else
			$display("** trivariate_polynomial_evaluator_unit: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire
